// ===== rtl/fdsu_pkg.sv =====
// fdsu_pkg: opcodes, result kinds and cell shift commands for the forth data stack unit
// used by fdsu_cell, forth_data_stack_unit and fdsu_checker; no dependencies
`default_nettype none

package fdsu_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned CELL_W          = 32;

    typedef enum logic [3:0] {
        OP_LIT   = 4'd0,
        OP_ADD   = 4'd1,
        OP_EQ    = 4'd2,
        OP_PRINT = 4'd3,
        OP_SHOW  = 4'd4,
        OP_DUP   = 4'd5,
        OP_DROP  = 4'd6,
        OP_NL    = 4'd7,
        OP_SWAP  = 4'd8,
        OP_OVER  = 4'd9
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NUM   = 2'd0,
        KIND_NL    = 2'd1,
        KIND_UNDER = 2'd2,
        KIND_OVER  = 2'd3
    } t_kind;

    // what every cell does at the clock; cell 0 is the top of stack
    typedef enum logic [2:0] {
        SH_HOLD,
        SH_PUSH,
        SH_DUP,
        SH_POP,
        SH_BINOP,
        SH_SWAP,
        SH_ROT
    } t_shift;

    typedef struct packed {
        t_shift op;
        logic   in_use;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/forth_data_stack_unit.sv =====
// forth_data_stack_unit: forth word executor on a chain of stack cells
// depends on fdsu_pkg and fdsu_cell
//
//  channel  | direction | handshake          | fields
//  input    | in        | i_valid / o_stall  | i_opcode, i_literal
//  result   | out       | o_valid / i_stall  | o_kind, o_value, o_last
//
// every word but show is done in the run state, so words issue back to back
// show is taken, then holds the input off in the show state while each stored cell is printed
// and the chain rotates once per printed cell
// the single output register sets the pace; a stalled result holds the input off
// reset (i_rst_n low, synchronous) empties the stack and drops any pending result
// cell contents are not reset; only cells below the depth count are ever read
`default_nettype none

module forth_data_stack_unit #(
    parameter int unsigned STACK_DEPTH = fdsu_pkg::STACK_DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [3:0]                         i_opcode,
    input  wire  signed [fdsu_pkg::CELL_W-1:0] i_literal,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [1:0]                         o_kind,
    output logic signed [fdsu_pkg::CELL_W-1:0] o_value,
    output logic                               o_last
);
    import fdsu_pkg::*;

    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IW = $clog2(STACK_DEPTH);

    typedef enum logic {
        ST_RUN,
        ST_SHOW
    } t_state;

    t_state                   r_state;
    logic [DW-1:0]            r_depth;
    logic [DW-1:0]            r_cnt;
    logic                     r_out_valid;
    t_kind                    r_kind;
    logic signed [CELL_W-1:0] r_value;
    logic                     r_last;

    logic signed [CELL_W-1:0] cell_q [STACK_DEPTH];
    t_cell_ctl                cell_ctl [STACK_DEPTH];

    logic                     out_free;
    logic                     take_in;
    t_opcode                  op;
    logic                     under;
    logic                     over;
    t_shift                   shift;
    logic signed [CELL_W-1:0] head;
    logic                     emit;
    t_kind                    emit_kind;
    logic signed [CELL_W-1:0] emit_value;
    logic                     emit_last;
    logic [DW-1:0]            n_depth;
    logic [IW-1:0]            bot_idx;
    logic                     show_step;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state == ST_SHOW) || !out_free;
    assign take_in   = i_valid && !o_stall;
    assign op        = t_opcode'(i_opcode);
    assign bot_idx   = IW'(r_depth - DW'(1));
    assign show_step = (r_state == ST_SHOW) && out_free;

    always_comb begin
        under = 1'b0;
        over  = 1'b0;
        if (op inside {OP_ADD, OP_EQ, OP_SWAP, OP_OVER}) begin
            under = (r_depth < DW'(2));
        end else if (op inside {OP_PRINT, OP_DUP, OP_DROP}) begin
            under = (r_depth == '0);
        end
        // over checks underflow first
        if (!under && (op inside {OP_LIT, OP_DUP, OP_OVER})) begin
            over = (r_depth >= DW'(STACK_DEPTH));
        end
    end

    always_comb begin
        shift      = SH_HOLD;
        head       = i_literal;
        emit       = 1'b0;
        emit_kind  = KIND_NUM;
        emit_value = '0;
        emit_last  = 1'b1;
        n_depth    = r_depth;
        if (show_step) begin
            shift      = SH_ROT;
            head       = cell_q[bot_idx];
            emit       = 1'b1;
            emit_value = cell_q[bot_idx];
            emit_last  = (r_cnt == DW'(1));
        end else if (take_in) begin
            if (under) begin
                emit      = 1'b1;
                emit_kind = KIND_UNDER;
            end else if (over) begin
                emit      = 1'b1;
                emit_kind = KIND_OVER;
            end else begin
                case (op)
                    OP_LIT: begin
                        shift   = SH_PUSH;
                        head    = i_literal;
                        n_depth = r_depth + DW'(1);
                    end
                    OP_ADD: begin
                        shift   = SH_BINOP;
                        head    = cell_q[0] + cell_q[1];
                        n_depth = r_depth - DW'(1);
                    end
                    OP_EQ: begin
                        shift   = SH_BINOP;
                        head    = (cell_q[0] == cell_q[1]) ? -32'sd1 : 32'sd0;
                        n_depth = r_depth - DW'(1);
                    end
                    OP_PRINT: begin
                        shift      = SH_POP;
                        emit       = 1'b1;
                        emit_value = cell_q[0];
                        n_depth    = r_depth - DW'(1);
                    end
                    OP_DUP: begin
                        shift   = SH_DUP;
                        n_depth = r_depth + DW'(1);
                    end
                    OP_DROP: begin
                        shift   = SH_POP;
                        n_depth = r_depth - DW'(1);
                    end
                    OP_NL: begin
                        emit      = 1'b1;
                        emit_kind = KIND_NL;
                    end
                    OP_SWAP: begin
                        shift = SH_SWAP;
                        head  = cell_q[1];
                    end
                    OP_OVER: begin
                        shift   = SH_PUSH;
                        head    = cell_q[1];
                        n_depth = r_depth + DW'(1);
                    end
                    default: begin
                        shift = SH_HOLD;
                    end
                endcase
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            logic signed [CELL_W-1:0] prev_d;
            logic signed [CELL_W-1:0] next_d;

            assign cell_ctl[gi].op     = shift;
            assign cell_ctl[gi].in_use = (DW'(gi) < r_depth);

            if (gi == 0) begin : g_head
                assign prev_d = head;
            end else begin : g_body
                assign prev_d = cell_q[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_tail
                assign next_d = '0;
            end else begin : g_link
                assign next_d = cell_q[gi+1];
            end

            fdsu_cell #(
                .CELL_IDX(gi)
            ) u_cell (
                .i_clk (i_clk),
                .i_ctl (cell_ctl[gi]),
                .i_prev(prev_d),
                .i_next(next_d),
                .o_q   (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_depth     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_depth <= n_depth;
            case (r_state)
                ST_RUN: begin
                    if (take_in && !under && (op == OP_SHOW) && (r_depth != '0)) begin
                        r_state <= ST_SHOW;
                        r_cnt   <= r_depth;
                    end
                end
                ST_SHOW: begin
                    if (show_step) begin
                        r_cnt <= r_cnt - DW'(1);
                        if (r_cnt == DW'(1)) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: r_state <= ST_RUN;
            endcase
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
        if (out_free && emit) begin
            r_kind  <= emit_kind;
            r_value <= emit_value;
            r_last  <= emit_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

`default_nettype wire

// ===== rtl/fdsu_cell.sv =====
// fdsu_cell: one stack cell of the chain, takes from its upper or lower neighbour
// depends on fdsu_pkg (t_cell_ctl, t_shift, CELL_W)
`default_nettype none

module fdsu_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire                               i_clk,
    input  fdsu_pkg::t_cell_ctl               i_ctl,
    input  wire signed [fdsu_pkg::CELL_W-1:0] i_prev,
    input  wire signed [fdsu_pkg::CELL_W-1:0] i_next,
    output logic signed [fdsu_pkg::CELL_W-1:0] o_q
);
    import fdsu_pkg::*;

    logic signed [CELL_W-1:0] r_q;
    logic signed [CELL_W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        case (i_ctl.op)
            SH_HOLD:  n_q = r_q;
            SH_PUSH:  n_q = i_prev;
            SH_DUP:   n_q = (CELL_IDX == 0) ? r_q : i_prev;
            SH_POP:   n_q = i_next;
            SH_BINOP: n_q = (CELL_IDX == 0) ? i_prev : i_next;
            SH_SWAP:  n_q = (CELL_IDX <= 1) ? i_prev : r_q;
            // only the occupied part of the chain turns round
            SH_ROT:   n_q = i_ctl.in_use ? i_prev : r_q;
            default:  n_q = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/fdsu_checker.sv =====
// fdsu_checker: port-level checks on the forth data stack unit, bound to the top level
// depends on fdsu_pkg and forth_data_stack_unit
`default_nettype none

module fdsu_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                o_stall,
    input wire                                o_valid,
    input wire                                i_stall,
    input wire [1:0]                          o_kind,
    input wire signed [fdsu_pkg::CELL_W-1:0]  o_value,
    input wire                                o_last
);
    import fdsu_pkg::*;

    // a stalled result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_value)
                               && $stable(o_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // newline and error items are single and carry no number
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_NUM) |-> o_last && (o_value == '0))
        else $error("non-number item not last or nonzero");

    // inside a show the input is held off
    a_show_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open during show");

    // show items follow each other without a gap
    a_show_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last && !i_stall |=> o_valid)
        else $error("gap inside show");

endmodule

bind forth_data_stack_unit fdsu_checker u_fdsu_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_kind (o_kind),
    .o_value(o_value),
    .o_last (o_last)
);

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking testbench for forth_data_stack_unit, one forth word per input item
// depends on fdsu_pkg and forth_data_stack_unit; a scoreboard class keeps a stack of its own
`default_nettype none

module tb;
    import fdsu_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    class stack_scoreboard;
        typedef struct packed {
            logic [1:0]  kind;
            logic [31:0] value;
            logic        last;
        } t_result;

        t_result     due_results[$];
        logic [31:0] cells[STACK_DEPTH];
        int          count;
        int          errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int depth();
            return count;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void add_result(t_kind kind, logic [31:0] value, logic last);
            t_result r;
            r.kind  = kind;
            r.value = value;
            r.last  = last;
            due_results.push_back(r);
        endfunction

        // runs one accepted word on the shadow stack and queues what it prints
        function void execute_word(logic [3:0] op, logic [31:0] lit);
            int          need;
            bit          grow;
            int          i;
            logic [31:0] a;
            need = 0;
            grow = 0;
            if (op > OP_OVER) return;
            case (op)
                OP_LIT: grow = 1;
                OP_ADD, OP_EQ, OP_SWAP: need = 2;
                OP_PRINT, OP_DROP: need = 1;
                OP_DUP: begin
                    need = 1;
                    grow = 1;
                end
                OP_OVER: begin
                    need = 2;
                    grow = 1;
                end
                default: ;
            endcase
            // underflow wins over overflow; either leaves the stack alone
            if (count < need) begin
                add_result(KIND_UNDER, '0, 1'b1);
                return;
            end
            if (grow && count >= STACK_DEPTH) begin
                add_result(KIND_OVER, '0, 1'b1);
                return;
            end
            case (op)
                OP_LIT: begin
                    cells[count] = lit;
                    count++;
                end
                OP_ADD: begin
                    cells[count-2] = cells[count-2] + cells[count-1];
                    count--;
                end
                OP_EQ: begin
                    cells[count-2] = (cells[count-2] == cells[count-1]) ? '1 : '0;
                    count--;
                end
                OP_PRINT: begin
                    count--;
                    add_result(KIND_NUM, cells[count], 1'b1);
                end
                OP_SHOW: begin
                    for (i = 0; i < count; i++)
                        add_result(KIND_NUM, cells[i], i == count - 1);
                end
                OP_DUP: begin
                    cells[count] = cells[count-1];
                    count++;
                end
                OP_DROP: count--;
                OP_NL: add_result(KIND_NL, '0, 1'b1);
                OP_SWAP: begin
                    a              = cells[count-1];
                    cells[count-1] = cells[count-2];
                    cells[count-2] = a;
                end
                default: begin
                    cells[count] = cells[count-2];
                    count++;
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [31:0] value, logic last);
            t_result want;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind=%0d value=%h last=%b", kind, value, last);
                return;
            end
            want = due_results.pop_front();
            if (kind !== want.kind || value !== want.value || last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected kind=%0d value=%h last=%b,",
                             want.kind, want.value, want.last,
                             " got kind=%0d value=%h last=%b", kind, value, last);
            end
        endfunction
    endclass

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [3:0]  i_opcode  = '0;
    logic [31:0] i_literal = '0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [31:0] o_value;
    logic        o_last;

    int src_idle_pct   = 19;
    int sink_stall_pct = 71;
    int cycle_count    = 0;

    stack_scoreboard sb = new();

    forth_data_stack_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_opcode),
        .i_literal(i_literal),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_kind   (o_kind),
        .o_value  (o_value),
        .o_last   (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // a result at this edge always belongs to an earlier item, so check before noting
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_kind, o_value, o_last);
            if (i_valid && !o_stall) sb.execute_word(i_opcode, i_literal);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // entered just after a falling edge, returns just after a falling edge
    task automatic send_word(input logic [3:0] op, input logic [31:0] lit);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_opcode  <= op;
        i_literal <= lit;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // bursts that mostly climb or mostly fall, so both full and empty stacks come up often
    task automatic run_random(input int n_words);
        int          sent;
        int          burst;
        bit          climb;
        int          r;
        logic [3:0]  op;
        logic [31:0] lit;
        sent  = 0;
        burst = 0;
        climb = 1;
        while (sent < n_words) begin
            if (burst == 0) begin
                climb = $urandom_range(1);
                burst = $urandom_range(30, 8);
            end
            burst--;
            r = $urandom_range(99);
            if (r < 4)
                op = 4'($urandom_range(15, 10));
            else if (r < 20)
                op = 4'($urandom_range(9, 0));
            else if (climb)
                op = (r < 65) ? OP_LIT : (r < 78) ? OP_DUP : (r < 88) ? OP_OVER :
                     (r < 92) ? OP_SHOW : (r < 96) ? OP_SWAP : OP_EQ;
            else
                op = (r < 45) ? OP_PRINT : (r < 60) ? OP_DROP : (r < 72) ? OP_ADD :
                     (r < 80) ? OP_EQ : (r < 88) ? OP_SWAP : (r < 94) ? OP_SHOW : OP_NL;
            case ($urandom_range(7))
                0: lit = 32'h8000_0000;
                1: lit = 32'h7FFF_FFFF;
                2: lit = 32'hFFFF_FFFF;
                3: lit = 32'($urandom_range(3));
                default: lit = $urandom();
            endcase
            send_word(op, lit);
            if (op <= OP_OVER) sent++;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack: underflow on every word that needs cells, show prints nothing
        send_word(OP_ADD, $urandom());
        send_word(OP_PRINT, $urandom());
        send_word(OP_DROP, $urandom());
        send_word(OP_DUP, $urandom());
        send_word(OP_SHOW, $urandom());
        send_word(OP_NL, $urandom());
        send_word(OP_UNUSED_HI, $urandom());
        send_word(OP_LIT, 32'h7FFF_FFFF);
        // one cell: two-cell words still underflow
        send_word(OP_OVER, $urandom());
        send_word(OP_SWAP, $urandom());
        send_word(OP_EQ, $urandom());
        send_word(OP_DUP, $urandom());
        send_word(OP_ADD, $urandom());
        send_word(OP_LIT, 32'h8000_0000);
        send_word(OP_SWAP, $urandom());
        send_word(OP_OVER, $urandom());
        send_word(OP_SHOW, $urandom());
        send_word(OP_EQ, $urandom());
        send_word(OP_DUP, $urandom());
        send_word(OP_EQ, $urandom());
        send_word(OP_UNUSED_LO, $urandom());
        send_word(OP_PRINT, $urandom());
        send_word(OP_SHOW, $urandom());

        run_random(150);
        src_idle_pct   = 71;
        sink_stall_pct = 19;
        run_random(150);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(150);
        i_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (3 * STACK_DEPTH) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
